// ----- hdl/pks_pkg.sv -----
// Shared constants and types for the priority key sorter.
package pks_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 16;
  localparam int FIELD_W     = 16;
  localparam int KEY_W       = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int TAG_W       = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = KEY_W + TAG_W;
  localparam int RANK_W      = KEY_W + IDX_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/pks_ram.sv -----
// Single write port, single registered read port entry memory.
module pks_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/priority_key_sorter.sv -----
// Priority key sorter: stable ascending sort of a list of key/tag entries.
//
// Input: an item (priority_req, tag, last) is taken at a rising edge where
// start is high and busy is low. Items load one per cycle into the entry
// memory. Entries past the capacity of 64 are dropped and the whole list is
// then reported with overflow set. The item with last high closes the list.
// After the closing item busy rises and the block emits the stored entries
// in ascending key order, equal keys in arrival order. Each result sits on
// priority_res, tag_res, last_res and overflow for one cycle with strobe
// high; the receiver cannot stall and must take it then. last_res marks the
// final result, after which busy falls and the next list may load.
// Each result is found by a full pass: every stored entry is read through
// the single read port and rank compare unit, the last read drains, the pass
// closes, and the result is emitted. Busy stays high until the final result.
// Reset clears the entry count, drop flag and sequencer; memory contents are
// not cleared and are only read below the entry count.
module priority_key_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] priority_req,
  input  logic [15:0] tag,
  input  logic        last,
  output logic        strobe,
  output logic [15:0] priority_res,
  output logic [15:0] tag_res,
  output logic        last_res,
  output logic        overflow
);

  pks_pkg::state_t state, state_next;

  logic [pks_pkg::CNT_W-1:0]   count;
  logic                        dropped;
  logic [pks_pkg::CNT_W-1:0]   rd_addr;
  logic                        rd_vld;
  logic [pks_pkg::IDX_W-1:0]   rd_idx;
  logic [pks_pkg::CNT_W-1:0]   out_cnt;
  logic [pks_pkg::RANK_W-1:0]  prev_rank;
  logic                        have_prev;
  logic [pks_pkg::RANK_W-1:0]  best_rank;
  logic [pks_pkg::TAG_W-1:0]   best_tag;
  logic                        best_vld;

  logic                        accept;
  logic                        store_we;
  logic                        full;
  logic [pks_pkg::ENTRY_W-1:0] rdata;
  logic [pks_pkg::KEY_W-1:0]   rd_key;
  logic [pks_pkg::RANK_W-1:0]  cand;
  logic                        above_prev;
  logic                        below_best;
  logic                        take;
  logic                        issue;
  logic                        final_res;

  assign accept   = start && !busy;
  assign full     = (count == pks_pkg::CNT_W'(pks_pkg::MAX_ENTRIES));
  assign store_we = accept && !full;
  assign issue    = (state == pks_pkg::ST_SCAN) && (rd_addr < count);

  pks_ram #(
    .DEPTH (pks_pkg::MAX_ENTRIES),
    .WIDTH (pks_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[pks_pkg::IDX_W-1:0]),
    .wdata ({priority_req[pks_pkg::KEY_W-1:0], tag}),
    .raddr (rd_addr[pks_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  // rank = {key, arrival index}: unique, and ordering it keeps the sort stable
  assign rd_key     = rdata[pks_pkg::ENTRY_W-1:pks_pkg::TAG_W];
  assign cand       = {rd_key, rd_idx};
  assign above_prev = !have_prev || (cand > prev_rank);
  assign below_best = !best_vld || (cand < best_rank);
  assign take       = rd_vld && above_prev && below_best;
  assign final_res  = ((out_cnt + 1'b1) == count);

  always_comb begin
    state_next = state;
    unique case (state)
      pks_pkg::ST_LOAD: begin
        if (accept && last) begin
          state_next = pks_pkg::ST_SCAN;
        end
      end
      pks_pkg::ST_SCAN: begin
        if (!issue && !rd_vld) begin
          state_next = pks_pkg::ST_EMIT;
        end
      end
      pks_pkg::ST_EMIT: begin
        state_next = final_res ? pks_pkg::ST_LOAD : pks_pkg::ST_SCAN;
      end
      default: state_next = pks_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    busy         = (state != pks_pkg::ST_LOAD);
    strobe       = (state == pks_pkg::ST_EMIT);
    priority_res = 16'(best_rank[pks_pkg::RANK_W-1:pks_pkg::IDX_W]);
    tag_res      = best_tag;
    last_res     = final_res;
    overflow     = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pks_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      rd_addr   <= '0;
      rd_vld    <= 1'b0;
      out_cnt   <= '0;
      have_prev <= 1'b0;
      best_vld  <= 1'b0;
    end else begin
      rd_vld <= issue;
      unique case (state)
        pks_pkg::ST_LOAD: begin
          rd_addr   <= '0;
          out_cnt   <= '0;
          have_prev <= 1'b0;
          best_vld  <= 1'b0;
          if (store_we) begin
            count <= count + 1'b1;
          end
          if (accept && full) begin
            dropped <= 1'b1;
          end
        end
        pks_pkg::ST_SCAN: begin
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (take) begin
            best_vld <= 1'b1;
          end
        end
        pks_pkg::ST_EMIT: begin
          rd_addr   <= '0;
          best_vld  <= 1'b0;
          have_prev <= 1'b1;
          out_cnt   <= out_cnt + 1'b1;
          if (final_res) begin
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          rd_addr <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr[pks_pkg::IDX_W-1:0];
    if (take) begin
      best_rank <= cand;
      best_tag  <= rdata[pks_pkg::TAG_W-1:0];
    end
    if (state == pks_pkg::ST_EMIT) begin
      prev_rank <= best_rank;
    end
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe outside busy");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !busy)
    else $error("busy after a non-closing item");

  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_res) |=> !busy)
    else $error("still busy after the final result");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back-to-back result strobes");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pks_pkg::CNT_W'(pks_pkg::MAX_ENTRIES))
    else $error("entry count past capacity");

  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    strobe |-> best_vld)
    else $error("emit without a selected entry");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the priority key sorter: queued stimulus, in-bench sort predictor, result checks.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [15:0] KEY_MASK =
    (pks_pkg::KEY_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << pks_pkg::KEY_BITS) - 1);

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
    logic        last;
    logic        ovf;
  } sorted_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] priority_req = '0;
  logic [15:0] tag = '0;
  logic        last = 1'b0;
  logic        busy;
  logic        strobe;
  logic [15:0] priority_res;
  logic [15:0] tag_res;
  logic        last_res;
  logic        overflow;

  entry_t      entry_q[$];
  sorted_t     sorted_q[$];
  logic [15:0] key_mem[pks_pkg::MAX_ENTRIES];
  logic [15:0] tag_mem[pks_pkg::MAX_ENTRIES];
  int          held = 0;
  logic        lost = 1'b0;
  int          idle_pct = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  logic        took = 1'b0;

  priority_key_sorter i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .priority_req (priority_req),
    .tag          (tag),
    .last         (last),
    .strobe       (strobe),
    .priority_res (priority_res),
    .tag_res      (tag_res),
    .last_res     (last_res),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one entry; on the closing entry emit the list in stable ascending key order.
  task automatic load_entry(input logic [15:0] key, input logic [15:0] tg, input logic close);
    int      order[pks_pkg::MAX_ENTRIES];
    int      i;
    int      j;
    int      cur;
    sorted_t r;
    if (held < pks_pkg::MAX_ENTRIES) begin
      key_mem[held] = key & KEY_MASK;
      tag_mem[held] = tg;
      held++;
    end else begin
      lost = 1'b1;
    end
    if (close) begin
      for (i = 0; i < held; i++) order[i] = i;
      for (i = 1; i < held; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && key_mem[order[j-1]] > key_mem[cur]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      for (i = 0; i < held; i++) begin
        r.key  = key_mem[order[i]];
        r.tag  = tag_mem[order[i]];
        r.last = (i == held - 1);
        r.ovf  = lost;
        sorted_q = {sorted_q, r};
      end
      held = 0;
      lost = 1'b0;
    end
  endtask

  // Driver: new item only when the bus is free or the previous item was taken.
  always @(negedge clk) begin
    entry_t e;
    if (!rst && (!start || took)) begin
      if (entry_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        e = entry_q.pop_front();
        start        <= 1'b1;
        priority_req <= e.key;
        tag          <= e.tag;
        last         <= e.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted items, check each strobed result.
  always @(posedge clk) begin
    sorted_t x;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else if (rst) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (took) load_entry(priority_req, tag, last);
      if (strobe) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: priority_res %h tag_res %h", priority_res, tag_res);
          errors++;
        end else begin
          x = sorted_q.pop_front();
          if (priority_res !== x.key) begin
            $error("priority_res: expected %h, got %h", x.key, priority_res);
            errors++;
          end
          if (tag_res !== x.tag) begin
            $error("tag_res: expected %h, got %h", x.tag, tag_res);
            errors++;
          end
          if (last_res !== x.last) begin
            $error("last_res: expected %b, got %b", x.last, last_res);
            errors++;
          end
          if (overflow !== x.ovf) begin
            $error("overflow: expected %b, got %b", x.ovf, overflow);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_item(input logic [15:0] key, input logic [15:0] tg, input logic close);
    entry_t e;
    e.key  = key;
    e.tag  = tg;
    e.last = close;
    entry_q = {entry_q, e};
  endtask

  function automatic logic [15:0] rand_key();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_list(input int n);
    int i;
    for (i = 0; i < n; i++) add_item(rand_key(), 16'($urandom()), i == n - 1);
  endtask

  task automatic add_lists(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
      add_list(n);
      sent += n;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (entry_q.size() != 0 || start || sorted_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int idle_tbl[3];
    int ph;
    idle_tbl = '{0, 70, 38};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-entry lists at the key and tag extremes
    add_item(16'hFFFF, 16'h0000, 1'b1);
    add_item(16'h0000, 16'hFFFF, 1'b1);
    // reversed order
    add_item(16'hFFFF, 16'h0001, 1'b0);
    add_item(16'h8000, 16'h0002, 1'b0);
    add_item(16'h1234, 16'h0003, 1'b0);
    add_item(16'h0001, 16'h0004, 1'b0);
    add_item(16'h0000, 16'h0005, 1'b1);
    // equal keys keep arrival order
    add_item(16'h0007, 16'hA001, 1'b0);
    add_item(16'h0003, 16'hA002, 1'b0);
    add_item(16'h0007, 16'hA003, 1'b0);
    add_item(16'h0003, 16'hA004, 1'b0);
    add_item(16'h0007, 16'hA005, 1'b1);
    // already sorted
    add_item(16'h0000, 16'hAAAA, 1'b0);
    add_item(16'hFFFF, 16'h5555, 1'b1);
    drain();

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = idle_tbl[ph];
      add_lists(4);
      if (ph == 2) begin
        add_list(pks_pkg::MAX_ENTRIES + 1 + $urandom_range(0, 3));
        add_lists(1);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
